[rtl/lpht_pkg.sv]
// Shared types and codes for the linear probing hash table.
`default_nettype none
package lpht_pkg;

    typedef logic [1:0] mode_t;
    localparam mode_t MODE_INSERT = 2'd0;
    localparam mode_t MODE_REMOVE = 2'd1;
    localparam mode_t MODE_LOOKUP = 2'd2;

    typedef logic [2:0] status_t;
    localparam status_t ST_OK       = 3'd0;
    localparam status_t ST_SAME     = 3'd1;
    localparam status_t ST_CONFLICT = 3'd2;
    localparam status_t ST_NOTFOUND = 3'd3;
    localparam status_t ST_FULL     = 3'd4;

    typedef logic [1:0] slot_t;
    localparam slot_t SLOT_EMPTY   = 2'd0;
    localparam slot_t SLOT_LIVE    = 2'd1;
    localparam slot_t SLOT_REMOVED = 2'd2;

    localparam int SLOT_OUT_W = 10;

    typedef struct packed {
        logic [31:0] object_handle;
        logic [31:0] key_value;
        logic [31:0] hash_value;
        mode_t       mode;
    } req_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } f_state_t;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_PROBE,
        B_CHECK
    } b_state_t;

endpackage
`default_nettype wire

[rtl/linear_probe_hash_table.sv]
// Top level of the linear probing hash table with tombstones.
// Path of a request: the front (start slot by reciprocal multiplication, queue push), the
// queue, and the back (RAM read, decision); every further probed slot adds another RAM read
// and decision. The front takes no new request until it has pushed the last one into the
// queue, and a probe holds the back part until its result is registered.
// Reset: asynchronous, active low, then a clear of all TABLE_SIZE slot states.
`default_nettype none
module linear_probe_hash_table #(
    parameter int TABLE_SIZE = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // hash_value [31:0], key_value [63:32], object_handle [95:64]
    input  wire logic [95:0] s_axis_tdata,
    // mode [1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // found_object [31:0], slot_index [41:32], zero [47:42]
    output logic [47:0]      m_axis_tdata,
    // status [2:0]
    output logic [2:0]       m_axis_tuser
);
    import lpht_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int Q_W   = $bits(req_t) + IDX_W;

    req_t                  s_req;
    req_t                  f_req;
    req_t                  b_req;
    logic [IDX_W-1:0]      f_start;
    logic [IDX_W-1:0]      b_start;
    logic                  f_valid;
    logic                  f_ready;
    logic                  b_valid;
    logic                  b_ready;
    logic                  clear_done;
    logic [Q_W-1:0]        q_out;
    status_t               status;
    logic [31:0]           found;
    logic [SLOT_OUT_W-1:0] slot;

    assign s_req.mode          = s_axis_tuser;
    assign s_req.hash_value    = s_axis_tdata[31:0];
    assign s_req.key_value     = s_axis_tdata[63:32];
    assign s_req.object_handle = s_axis_tdata[95:64];

    lpht_front #(.TABLE_SIZE(TABLE_SIZE)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear_done (clear_done),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_req      (s_req),
        .q_valid    (f_valid),
        .q_ready    (f_ready),
        .q_req      (f_req),
        .q_start    (f_start)
    );

    lpht_queue #(.WIDTH(Q_W)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   ({f_req, f_start}),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (q_out)
    );

    assign b_req   = q_out[Q_W-1:IDX_W];
    assign b_start = q_out[IDX_W-1:0];

    lpht_back #(.TABLE_SIZE(TABLE_SIZE)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear_done (clear_done),
        .q_valid    (b_valid),
        .q_ready    (b_ready),
        .q_req      (b_req),
        .q_start    (b_start),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (status),
        .out_found  (found),
        .out_slot   (slot)
    );

    assign m_axis_tdata = {6'd0, slot, found};
    assign m_axis_tuser = status;
endmodule
`default_nettype wire

[rtl/lpht_ram.sv]
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[rtl/lpht_queue.sv]
// Two-entry queue between the front and back parts.
`default_nettype none
module lpht_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [WIDTH-1:0] out_data
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wptr_reg;
    logic             rptr_reg;
    logic [1:0]       count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end
endmodule
`default_nettype wire

[rtl/lpht_front.sv]
// Front part: accepts requests and computes the start slot, hash modulo table size.
`default_nettype none
module lpht_front #(
    parameter int TABLE_SIZE = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          clear_done,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire lpht_pkg::req_t                s_req,
    output logic                               q_valid,
    input  wire logic                          q_ready,
    output lpht_pkg::req_t                     q_req,
    output logic [$clog2(TABLE_SIZE)-1:0]      q_start
);
    import lpht_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam logic [31:0] TSIZE = 32'(TABLE_SIZE);
    // Reciprocal of the table size scaled by 2**32; the quotient estimate is low by at most one.
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / TABLE_SIZE);

    f_state_t          state_reg;
    f_state_t          state_next;
    req_t              req_reg;
    logic [31:0]       quot_reg;
    logic [31:0]       diff_reg;
    logic [IDX_W-1:0]  rem_reg;
    logic [1:0]        cnt_reg;
    logic              accept;
    logic [63:0]       prod;
    logic [31:0]       diff_next;
    logic [31:0]       rem_next;

    assign accept = s_valid && s_ready;

    // Three register stages: quotient estimate, remainder estimate below twice the size,
    // then one conditional subtraction.
    assign prod      = 64'(req_reg.hash_value) * 64'(RECIP);
    assign diff_next = req_reg.hash_value - quot_reg * TSIZE;
    assign rem_next  = (diff_reg >= TSIZE) ? diff_reg - TSIZE : diff_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_DIV;
                end
            end
            F_DIV:
            begin
                if (cnt_reg == 2'd2)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (q_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_ready = 1'b0;
        q_valid = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                s_ready = clear_done;
            end
            F_PUSH:
            begin
                q_valid = 1'b1;
            end
            default:
            begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign q_req   = req_reg;
    assign q_start = rem_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= s_req;
        end
        else if (state_reg == F_DIV)
        begin
            quot_reg <= prod[63:32];
            diff_reg <= diff_next;
            rem_reg  <= rem_next[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                cnt_reg <= 2'd0;
            end
            else if (state_reg == F_DIV)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
        end
    end
endmodule
`default_nettype wire

[rtl/lpht_back.sv]
// Back part: clears the slot states, probes the table and registers the result.
`default_nettype none
module lpht_back #(
    parameter int TABLE_SIZE = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    output logic                               clear_done,
    input  wire logic                          q_valid,
    output logic                               q_ready,
    input  wire lpht_pkg::req_t                q_req,
    input  wire logic [$clog2(TABLE_SIZE)-1:0] q_start,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output lpht_pkg::status_t                  out_status,
    output logic [31:0]                        out_found,
    output logic [lpht_pkg::SLOT_OUT_W-1:0]    out_slot
);
    import lpht_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_SIZE - 1);

    b_state_t          state_reg;
    b_state_t          state_next;
    req_t              req_reg;
    logic [IDX_W-1:0]  pos_reg;
    logic [IDX_W-1:0]  cnt_reg;
    logic [IDX_W-1:0]  clr_reg;
    logic              out_valid_reg;
    status_t           status_reg;
    logic [31:0]       found_reg;
    logic [SLOT_OUT_W-1:0] slot_reg;

    slot_t             s_rd;
    logic [95:0]       e_rd;
    logic              match;
    logic              fin;
    logic              st_we;
    slot_t             st_wdata;
    logic              ent_we;
    logic              out_free;
    logic              commit;
    status_t           res_status;
    logic [31:0]       res_found;
    logic [31:0]       pos_wide;
    logic [IDX_W-1:0]  st_waddr;

    lpht_ram #(.WIDTH(2), .DEPTH(TABLE_SIZE)) u_state_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (pos_reg),
        .rdata (s_rd)
    );

    lpht_ram #(.WIDTH(96), .DEPTH(TABLE_SIZE)) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (pos_reg),
        .wdata ({req_reg.object_handle, req_reg.key_value, req_reg.hash_value}),
        .raddr (pos_reg),
        .rdata (e_rd)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign match    = (e_rd[31:0] == req_reg.hash_value) && (e_rd[63:32] == req_reg.key_value);
    assign commit   = fin && out_free;
    assign pos_wide = 32'(pos_reg);

    // Decision on the slot whose state and entry were read in the previous cycle.
    always_comb
    begin
        logic st_w;
        logic ent_w;
        fin        = 1'b0;
        st_w       = 1'b0;
        ent_w      = 1'b0;
        st_wdata   = SLOT_EMPTY;
        res_status = ST_NOTFOUND;
        res_found  = 32'd0;
        if (state_reg == B_CHECK)
        begin
            case (req_reg.mode)
                MODE_INSERT:
                begin
                    if (s_rd != SLOT_LIVE)
                    begin
                        fin        = 1'b1;
                        st_w       = 1'b1;
                        ent_w      = 1'b1;
                        st_wdata   = SLOT_LIVE;
                        res_status = ST_OK;
                    end
                    else if (match)
                    begin
                        fin        = 1'b1;
                        res_status = (e_rd[95:64] == req_reg.object_handle) ? ST_SAME
                                                                           : ST_CONFLICT;
                    end
                    else if (cnt_reg == LAST)
                    begin
                        fin        = 1'b1;
                        res_status = ST_FULL;
                    end
                end
                MODE_REMOVE, MODE_LOOKUP:
                begin
                    if (s_rd == SLOT_EMPTY)
                    begin
                        fin = 1'b1;
                    end
                    else if (s_rd == SLOT_LIVE && match)
                    begin
                        fin        = 1'b1;
                        res_status = ST_OK;
                        if (req_reg.mode == MODE_REMOVE)
                        begin
                            st_w     = 1'b1;
                            st_wdata = SLOT_REMOVED;
                        end
                        else
                        begin
                            res_found = e_rd[95:64];
                        end
                    end
                    else if (cnt_reg == LAST)
                    begin
                        fin = 1'b1;
                    end
                end
                default:
                begin
                    fin = 1'b1;
                end
            endcase
        end
        if (state_reg == B_CLEAR)
        begin
            st_we    = 1'b1;
            st_waddr = clr_reg;
        end
        else
        begin
            st_we    = st_w && out_free;
            st_waddr = pos_reg;
        end
        ent_we = ent_w && out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_CLEAR:
            begin
                if (clr_reg == LAST)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = (q_req.mode inside {MODE_INSERT, MODE_REMOVE, MODE_LOOKUP})
                                 ? B_PROBE : B_CHECK;
                end
            end
            B_PROBE:
            begin
                state_next = B_CHECK;
            end
            B_CHECK:
            begin
                if (commit)
                begin
                    state_next = B_IDLE;
                end
                else if (!fin)
                begin
                    state_next = B_PROBE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_ready    = 1'b0;
        clear_done = 1'b1;
        case (state_reg)
            B_CLEAR:
            begin
                clear_done = 1'b0;
            end
            B_IDLE:
            begin
                q_ready = 1'b1;
            end
            default:
            begin
                q_ready = 1'b0;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign out_status = status_reg;
    assign out_found  = found_reg;
    assign out_slot   = slot_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == B_IDLE && q_valid)
        begin
            req_reg <= q_req;
        end
        if (commit)
        begin
            status_reg <= res_status;
            found_reg  <= res_found;
            slot_reg   <= (res_status inside {ST_OK, ST_SAME, ST_CONFLICT})
                          ? pos_wide[SLOT_OUT_W-1:0] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == B_IDLE && q_valid)
            begin
                pos_reg <= q_start;
                cnt_reg <= '0;
            end
            else if (state_reg == B_CHECK && !fin)
            begin
                pos_reg <= (pos_reg == LAST) ? '0 : pos_reg + 1'b1;
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

[bench/linear_probe_hash_table_tb.sv]
// Self-checking testbench for the linear probing hash table.
`timescale 1ns / 100ps
`default_nettype none

module linear_probe_hash_table_tb;
    import lpht_pkg::*;

    localparam int TBL = 1024;
    localparam int CYCLE_LIMIT = 20000000;
    localparam mode_t MODE_NONE = 2'd3;

    typedef struct packed {
        status_t     status;
        logic [31:0] found_object;
        logic [9:0]  slot_index;
    } answer_t;

    class table_scoreboard;
        slot_t       st[TBL];
        logic [31:0] eh[TBL];
        logic [31:0] ek[TBL];
        logic [31:0] eo[TBL];
        answer_t     pending[$];
        int          errors;

        function new();
            foreach (st[i])
            begin
                st[i] = SLOT_EMPTY;
            end
            errors = 0;
        endfunction

        // Predicts the answer to one accepted request and updates the table copy.
        function void note_request(mode_t m, logic [31:0] h, logic [31:0] k,
                                   logic [31:0] o);
            answer_t a;
            int pos;
            bit done;
            a = '{ST_NOTFOUND, 32'd0, 10'd0};
            pos = h % TBL;
            done = 0;
            if (m == MODE_INSERT)
            begin
                a.status = ST_FULL;
                for (int n = 0; n < TBL && !done; n++)
                begin
                    if (st[pos] != SLOT_LIVE)
                    begin
                        st[pos] = SLOT_LIVE;
                        eh[pos] = h;
                        ek[pos] = k;
                        eo[pos] = o;
                        a.status = ST_OK;
                        a.slot_index = 10'(pos);
                        done = 1;
                    end
                    else if (eh[pos] == h && ek[pos] == k)
                    begin
                        a.status = (eo[pos] == o) ? ST_SAME : ST_CONFLICT;
                        a.slot_index = 10'(pos);
                        done = 1;
                    end
                    pos = (pos + 1) % TBL;
                end
            end
            else if (m == MODE_REMOVE || m == MODE_LOOKUP)
            begin
                for (int n = 0; n < TBL && !done; n++)
                begin
                    if (st[pos] == SLOT_EMPTY)
                    begin
                        done = 1;
                    end
                    else if (st[pos] == SLOT_LIVE && eh[pos] == h && ek[pos] == k)
                    begin
                        a.status = ST_OK;
                        a.slot_index = 10'(pos);
                        if (m == MODE_REMOVE)
                        begin
                            st[pos] = SLOT_REMOVED;
                        end
                        else
                        begin
                            a.found_object = eo[pos];
                        end
                        done = 1;
                    end
                    if (!done)
                    begin
                        pos = (pos + 1) % TBL;
                    end
                end
            end
            pending.push_back(a);
        endfunction

        function void check_answer(answer_t got);
            answer_t exp;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
                errors++;
            end
            if (got.found_object !== exp.found_object)
            begin
                $display("%0t: found_object expected %h actual %h", $time,
                         exp.found_object, got.found_object);
                errors++;
            end
            if (got.slot_index !== exp.slot_index)
            begin
                $display("%0t: slot_index expected %0d actual %0d", $time,
                         exp.slot_index, got.slot_index);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [47:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    table_scoreboard sb;
    int  cycles = 0;
    bit  rx_stall_on = 1;

    // Keys drawn from a small pool so that repeats, removes and conflicts happen.
    logic [31:0] key_pool[16];
    logic [31:0] hash_pool[16];

    always #10 clk = ~clk;

    linear_probe_hash_table #(.TABLE_SIZE(TBL)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: random ready stalls while rx_stall_on is set, check each transfer.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_answer('{m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[41:32]});
        end
        if (rx_stall_on)
        begin
            m_axis_tready <= ($urandom_range(0, 4) == 0) ? 1'b1 : ($urandom_range(0, 1) == 1);
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Valid stays high after a transfer so that a following item can go back to back.
    task automatic send(mode_t m, logic [31:0] h, logic [31:0] k, logic [31:0] o,
                        bit idle);
        int gap;
        gap = idle ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= m;
        s_axis_tdata  <= {o, k, h};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_request(m, h, k, o);
    endtask

    task automatic stop_input();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    task automatic random_request(bit idle);
        int r, p;
        mode_t m;
        logic [31:0] h, k, o;
        r = $urandom_range(0, 99);
        p = $urandom_range(0, 15);
        h = hash_pool[p];
        k = key_pool[p];
        o = $urandom_range(1, 6);
        if (r < 40)
        begin
            m = MODE_INSERT;
        end
        else if (r < 65)
        begin
            m = MODE_REMOVE;
        end
        else if (r < 97)
        begin
            m = MODE_LOOKUP;
        end
        else
        begin
            m = MODE_NONE;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            h = $urandom();
            k = $urandom();
            o = $urandom();
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            k = k ^ 32'h1;
        end
        send(m, h, k, o, idle);
    endtask

    initial
    begin
        sb = new();
        for (int i = 0; i < 16; i++)
        begin
            // Several keys share a start slot so probe chains form and wrap.
            hash_pool[i] = (i < 8) ? ($urandom() & 32'hFFFF_FC00) | 32'h3FE
                                   : $urandom();
            key_pool[i] = $urandom();
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: field extremes, all modes, duplicates, wrap, tombstones.
        send(MODE_LOOKUP, 32'h0, 32'h0, 32'h1, 0);
        send(MODE_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 0);
        send(MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send(MODE_INSERT, 32'hFFFF_FFFF, 32'h0, 32'h0, 0);
        send(MODE_INSERT, 32'h0000_03FF, 32'h5, 32'h7, 1);
        send(MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
        send(MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678, 1);
        send(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h1, 1);
        send(MODE_LOOKUP, 32'h0000_03FF, 32'h5, 32'h1, 1);
        send(MODE_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 1);
        send(MODE_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 1);
        send(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h1, 1);
        send(MODE_INSERT, 32'hFFFF_FFFF, 32'h0, 32'h9, 1);
        send(MODE_INSERT, 32'h0000_03FF, 32'hAAAA_AAAA, 32'h5555_5555, 1);
        send(MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
        send(MODE_REMOVE, 32'h0000_03FF, 32'h6, 32'h1, 1);

        // The sender holds off until every result is back.
        stop_input();
        drain();

        for (int i = 0; i < 360; i++)
        begin
            if (i == 100)
            begin
                rx_stall_on = 0;
            end
            if (i == 180)
            begin
                rx_stall_on = 1;
            end
            random_request(!(i >= 250 && i < 300));
        end

        // Fill the table completely, then probe the full-table cases.
        for (int i = 0; i < TBL; i++)
        begin
            send(MODE_INSERT, $urandom(), $urandom(), $urandom_range(1, 100), 0);
        end
        send(MODE_INSERT, 32'h0, 32'hDEAD_0001, 32'h1, 1);
        send(MODE_LOOKUP, 32'h0, 32'hDEAD_0002, 32'h1, 1);
        send(MODE_REMOVE, 32'h123, 32'hDEAD_0003, 32'h1, 1);
        stop_input();

        drain();
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

`default_nettype wire
